[rtl/core/alle_pkg.sv]
// shared types and constants of the array linked list engine
package alle_pkg;

  // fixed port widths
  localparam int PORT_PAY_BITS = 32;
  localparam int SLOT_IDX_BITS = 8;
  localparam int STATUS_BITS   = 2;

  // action codes of an input word
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // status codes of a result word
  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd3;

  // operation class decided when a word is taken
  typedef enum logic [2:0] {
    OP_INS,
    OP_FULL,
    OP_REM,
    OP_EMPTY,
    OP_BAD
  } op_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;   // word taken: decode and issue the link reads
    logic finish;  // write back links and load the result register
  } ctl_cmd_t;

endpackage

[rtl/core/alle_ctrl.sv]
// controller state machine of the array linked list engine
module alle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output alle_pkg::ctl_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_t;

  state_t state;
  logic   room;

  // result register free or being emptied this cycle
  assign room       = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);
  assign cmd.start  = in_valid && (state == S_IDLE);
  assign cmd.finish = (state == S_FIN) && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (room) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/alle_datapath.sv]
// link memories, list pointers and result register of the array linked list engine
module alle_datapath #(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  alle_pkg::ctl_cmd_t                   cmd,
  input  logic                                 action,
  input  logic [alle_pkg::PORT_PAY_BITS-1:0]   payload,
  input  logic [alle_pkg::SLOT_IDX_BITS-1:0]   slot_index,
  output logic [alle_pkg::STATUS_BITS-1:0]     status,
  output logic [alle_pkg::SLOT_IDX_BITS-1:0]   slot_used,
  output logic [alle_pkg::PORT_PAY_BITS-1:0]   removed_payload,
  output logic                                 is_full,
  output logic                                 is_empty
);

  localparam int SW  = $clog2(SLOTS);
  localparam int LW  = SW + 1;
  localparam int PB  = (PAYLOAD_BITS < alle_pkg::PORT_PAY_BITS) ?
                       PAYLOAD_BITS : alle_pkg::PORT_PAY_BITS;
  localparam int LN  = (SLOTS < (1 << alle_pkg::SLOT_IDX_BITS)) ?
                       SLOTS : (1 << alle_pkg::SLOT_IDX_BITS);
  localparam int LNW = $clog2(LN);
  localparam logic [LW-1:0] NIL = {LW{1'b1}};

  // link memories and payload store
  logic [LW-1:0] nxt_mem [SLOTS];
  logic [LW-1:0] prv_mem [SLOTS];
  logic [PB-1:0] pay_mem [SLOTS];
  logic [LW-1:0] nxt_rd, prv_rd;
  logic [PB-1:0] pay_rd;

  // list state
  logic [LW-1:0] head, tail, free_top;
  logic [SW:0]   fill;
  logic [LN-1:0] in_list;

  // request held between the two phases
  alle_pkg::op_t op;
  logic [SW-1:0] req_slot;

  alle_pkg::op_t op_next;
  logic [SW-1:0] s_ins, s_rem, rd_a;
  logic [16:0]   idx_wide;
  logic          in_range, listed;
  logic          fresh;
  logic [LW-1:0] inc, fresh_next, pop_next;
  logic [LW-1:0] p, n;
  logic [alle_pkg::PORT_PAY_BITS-1:0] rd_ext;

  logic          nxt_we, prv_we, pay_we;
  logic [SW-1:0] nxt_wa, prv_wa, pay_wa;
  logic [LW-1:0] nxt_wd, prv_wd;
  logic [PB-1:0] pay_wd;

  assign s_ins    = free_top[SW-1:0];
  assign s_rem    = SW'(slot_index);
  assign idx_wide = 17'(slot_index);
  assign in_range = idx_wide < 17'(SLOTS);
  assign listed   = in_range && in_list[LNW'(slot_index)];
  assign rd_a     = (action == alle_pkg::ACT_INSERT) ? s_ins : s_rem;

  assign p = prv_rd;
  assign n = nxt_rd;

  // slots at or above the fill mark were never written: next link slot+1 or NIL
  assign fresh      = {1'b0, req_slot} >= fill;
  assign inc        = {1'b0, req_slot} + LW'(1);
  assign fresh_next = (inc == LW'(SLOTS)) ? NIL : inc;
  assign pop_next   = fresh ? fresh_next : nxt_rd;

  always_comb begin
    rd_ext = '0;
    rd_ext[PB-1:0] = pay_rd;
  end

  // decode of the incoming word
  always_comb begin
    if (action == alle_pkg::ACT_INSERT) begin
      op_next = free_top[LW-1] ? alle_pkg::OP_FULL : alle_pkg::OP_INS;
    end else if (head[LW-1]) begin
      op_next = alle_pkg::OP_EMPTY;
    end else if (!listed) begin
      op_next = alle_pkg::OP_BAD;
    end else begin
      op_next = alle_pkg::OP_REM;
    end
  end

  // memory write selection, first phase on start, second on finish
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = '0;
    prv_we = 1'b0;
    prv_wa = '0;
    prv_wd = '0;
    pay_we = 1'b0;
    pay_wa = s_ins;
    pay_wd = payload[PB-1:0];
    if (cmd.start) begin
      if (op_next == alle_pkg::OP_INS) begin
        // old tail gains the new slot as successor
        nxt_we = !tail[LW-1];
        nxt_wa = tail[SW-1:0];
        nxt_wd = {1'b0, s_ins};
        prv_we = 1'b1;
        prv_wa = s_ins;
        prv_wd = tail;
        pay_we = 1'b1;
      end else if (op_next == alle_pkg::OP_REM) begin
        // freed slot goes on the free stack; old link read in the same cycle
        nxt_we = 1'b1;
        nxt_wa = s_rem;
        nxt_wd = free_top;
      end
    end else if (cmd.finish) begin
      if (op == alle_pkg::OP_INS) begin
        nxt_we = 1'b1;
        nxt_wa = req_slot;
        nxt_wd = NIL;
      end else if (op == alle_pkg::OP_REM) begin
        nxt_we = !p[LW-1];
        nxt_wa = p[SW-1:0];
        nxt_wd = n;
        prv_we = !n[LW-1];
        prv_wa = n[SW-1:0];
        prv_wd = p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (cmd.start) begin
      nxt_rd <= nxt_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (cmd.start) begin
      prv_rd <= prv_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[pay_wa] <= pay_wd;
    end
    if (cmd.start) begin
      pay_rd <= pay_mem[rd_a];
    end
  end

  // list pointers, fill mark and membership bits
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NIL;
      tail     <= NIL;
      free_top <= '0;
      fill     <= '0;
      in_list  <= '0;
    end else if (cmd.finish) begin
      case (op)
        alle_pkg::OP_INS: begin
          free_top <= pop_next;
          if (head[LW-1]) begin
            head <= {1'b0, req_slot};
          end
          tail <= {1'b0, req_slot};
          if (fresh) begin
            fill <= fill + (SW+1)'(1);
          end
          if ({1'b0, req_slot} < (SW+1)'(LN)) begin
            in_list[LNW'(req_slot)] <= 1'b1;
          end
        end
        alle_pkg::OP_REM: begin
          if (p[LW-1]) begin
            head <= n;
          end
          if (n[LW-1]) begin
            tail <= p;
          end
          free_top <= {1'b0, req_slot};
          in_list[LNW'(req_slot)] <= 1'b0;
        end
        default: begin
          free_top <= free_top;
        end
      endcase
    end
  end

  // request latch and result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op       <= op_next;
      req_slot <= rd_a;
    end
    if (cmd.finish) begin
      case (op)
        alle_pkg::OP_INS: begin
          status          <= alle_pkg::ST_DONE;
          slot_used       <= alle_pkg::SLOT_IDX_BITS'(req_slot);
          removed_payload <= '0;
          is_full         <= pop_next[LW-1];
          is_empty        <= 1'b0;
        end
        alle_pkg::OP_REM: begin
          status          <= alle_pkg::ST_DONE;
          slot_used       <= alle_pkg::SLOT_IDX_BITS'(req_slot);
          removed_payload <= rd_ext;
          is_full         <= 1'b0;
          is_empty        <= p[LW-1] && n[LW-1];
        end
        alle_pkg::OP_FULL: begin
          status          <= alle_pkg::ST_FULL;
          slot_used       <= '0;
          removed_payload <= '0;
          is_full         <= free_top[LW-1];
          is_empty        <= head[LW-1];
        end
        alle_pkg::OP_EMPTY: begin
          status          <= alle_pkg::ST_EMPTY;
          slot_used       <= '0;
          removed_payload <= '0;
          is_full         <= free_top[LW-1];
          is_empty        <= head[LW-1];
        end
        default: begin
          status          <= alle_pkg::ST_BAD;
          slot_used       <= '0;
          removed_payload <= '0;
          is_full         <= free_top[LW-1];
          is_empty        <= head[LW-1];
        end
      endcase
    end
  end

endmodule

[rtl/core/array_linked_list_engine_top.sv]
// top level of the array linked list engine: doubly linked list in a slot array
// result: a result word is loaded in the finish state after its input word is taken, later
//   while the previous result word is still stalled at the output
// words: a new word is taken only once the previous one is finished, set by the registered
//   link read on taking a word followed by the neighbour link write-back on finishing it
// reset: synchronous, clears pointers, fill mark and membership bits; the link
//   memories need no clearing pass since never-written slots are tracked by the fill mark
module array_linked_list_engine_top #(
  parameter int SLOTS        = 256,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [alle_pkg::PORT_PAY_BITS-1:0]   payload,
  input  logic [alle_pkg::SLOT_IDX_BITS-1:0]   slot_index,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [alle_pkg::STATUS_BITS-1:0]     status,
  output logic [alle_pkg::SLOT_IDX_BITS-1:0]   slot_used,
  output logic [alle_pkg::PORT_PAY_BITS-1:0]   removed_payload,
  output logic                                 is_full,
  output logic                                 is_empty
);

  // start and finish strobes for the datapath
  alle_pkg::ctl_cmd_t cmd;

  // two-state sequencer: take a word, then finish it once the result register is free
  alle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // link memories, free stack top, head and tail, and the result register
  alle_datapath #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .action          (action),
    .payload         (payload),
    .slot_index      (slot_index),
    .status          (status),
    .slot_used       (slot_used),
    .removed_payload (removed_payload),
    .is_full         (is_full),
    .is_empty        (is_empty)
  );

endmodule

[sim/alle_list_checker.sv]
// result checker of the array linked list engine: shadow list, expected words and compare
module alle_list_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                action,
  input  logic [alle_pkg::PORT_PAY_BITS-1:0]  payload,
  input  logic [alle_pkg::SLOT_IDX_BITS-1:0]  slot_index,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [alle_pkg::STATUS_BITS-1:0]    status,
  input  logic [alle_pkg::SLOT_IDX_BITS-1:0]  slot_used,
  input  logic [alle_pkg::PORT_PAY_BITS-1:0]  removed_payload,
  input  logic                                is_full,
  input  logic                                is_empty,
  output int unsigned                         mismatches,
  output int unsigned                         outstanding
);

  localparam int SLOT_COUNT = 256;
  localparam logic [8:0] NO_SLOT = 9'h1FF;

  typedef struct packed {
    logic [alle_pkg::STATUS_BITS-1:0]   status;
    logic [alle_pkg::SLOT_IDX_BITS-1:0] slot;
    logic [alle_pkg::PORT_PAY_BITS-1:0] pay;
    logic                               full;
    logic                               empty;
  } list_result_t;

  logic [alle_pkg::PORT_PAY_BITS-1:0] stored_pay [SLOT_COUNT];
  logic [8:0]               fwd_link   [SLOT_COUNT];
  logic [8:0]               back_link  [SLOT_COUNT];
  bit                       linked     [SLOT_COUNT];
  logic [8:0]               first_slot, last_slot, spare_top;
  list_result_t             result_q[$];
  list_result_t             got_word, want_word;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic clear_list_model();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      fwd_link[i]  = (i < SLOT_COUNT - 1) ? 9'(i + 1) : NO_SLOT;
      back_link[i] = NO_SLOT;
      linked[i]    = 1'b0;
    end
    first_slot = NO_SLOT;
    last_slot  = NO_SLOT;
    spare_top  = '0;
  endtask

  // one list operation on the shadow state, giving the word it should produce
  task automatic apply_list_op(input logic act,
                               input logic [alle_pkg::PORT_PAY_BITS-1:0] pay,
                               input logic [alle_pkg::SLOT_IDX_BITS-1:0] idx,
                               output list_result_t r);
    logic [8:0] s, p, n;
    r = '0;
    if (act == alle_pkg::ACT_INSERT) begin
      if (spare_top == NO_SLOT) begin
        r.status = alle_pkg::ST_FULL;
      end else begin
        s = spare_top;
        spare_top = fwd_link[s[7:0]];
        stored_pay[s[7:0]] = pay;
        fwd_link[s[7:0]] = NO_SLOT;
        linked[s[7:0]] = 1'b1;
        if (first_slot == NO_SLOT) begin
          back_link[s[7:0]] = NO_SLOT;
          first_slot = s;
        end else begin
          back_link[s[7:0]] = last_slot;
          fwd_link[last_slot[7:0]] = s;
        end
        last_slot = s;
        r.status = alle_pkg::ST_DONE;
        r.slot = s[7:0];
      end
    end else if (first_slot == NO_SLOT) begin
      r.status = alle_pkg::ST_EMPTY;
    end else if (!linked[idx]) begin
      r.status = alle_pkg::ST_BAD;
    end else begin
      p = back_link[idx];
      n = fwd_link[idx];
      r.pay = stored_pay[idx];
      if (p == NO_SLOT) first_slot = n;
      else fwd_link[p[7:0]] = n;
      if (n == NO_SLOT) last_slot = p;
      else back_link[n[7:0]] = p;
      linked[idx] = 1'b0;
      back_link[idx] = NO_SLOT;
      fwd_link[idx] = spare_top;
      spare_top = {1'b0, idx};
      r.status = alle_pkg::ST_DONE;
      r.slot = idx;
    end
    r.full  = (spare_top == NO_SLOT);
    r.empty = (first_slot == NO_SLOT);
  endtask

  // one line per mismatch, and the count
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_list_model();
      result_q.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_word = '{status, slot_used, removed_payload, is_full, is_empty};
        if (result_q.size() == 0) begin
          flag_mismatch("result word with nothing expected", got_word.pay, '0);
        end else begin
          want_word = result_q.pop_front();
          if (got_word.status != want_word.status)
            flag_mismatch("status", 32'(got_word.status), 32'(want_word.status));
          if (got_word.slot != want_word.slot)
            flag_mismatch("slot_used", 32'(got_word.slot), 32'(want_word.slot));
          if (got_word.pay != want_word.pay)
            flag_mismatch("removed_payload", got_word.pay, want_word.pay);
          if (got_word.full != want_word.full)
            flag_mismatch("is_full", 32'(got_word.full), 32'(want_word.full));
          if (got_word.empty != want_word.empty)
            flag_mismatch("is_empty", 32'(got_word.empty), 32'(want_word.empty));
        end
      end
      if (in_valid && !in_stall) begin
        apply_list_op(action, payload, slot_index, want_word);
        result_q.push_back(want_word);
      end
      outstanding <= result_q.size();
    end
  end

endmodule

[sim/tb_array_linked_list_engine_top.sv]
// testbench top of the array linked list engine: stimulus, idling, watchdog and verdict
module tb_array_linked_list_engine_top;

  // stimulus stops once at least this many words are sent, directed part included
  localparam int TOTAL_WORDS = 1050;
  // words in this range go through with no idling on either side
  localparam int QUIET_FROM  = 500;
  localparam int QUIET_TO    = 650;
  // percentage of cycles in which a side idles
  localparam int IDLE_PCT    = 23;
  // cycles with no accepted word before the run is called hung
  localparam int STUCK_LIMIT = 1000;
  // settling time after the last result
  localparam int TAIL_CYCLES = 10;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = alle_pkg::ACT_INSERT;
  logic [alle_pkg::PORT_PAY_BITS-1:0] payload = '0;
  logic [alle_pkg::SLOT_IDX_BITS-1:0] slot_index = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [alle_pkg::STATUS_BITS-1:0]   status;
  logic [alle_pkg::SLOT_IDX_BITS-1:0] slot_used;
  logic [alle_pkg::PORT_PAY_BITS-1:0] removed_payload;
  logic                     is_full;
  logic                     is_empty;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned words_sent = 0;
  int unsigned stuck_cycles = 0;
  bit          quiet = 1'b0;

  // light stimulus-side view of the list, only used to pick sensible slots:
  // entries in list order, and the free stack with its top at the front
  logic [alle_pkg::SLOT_IDX_BITS-1:0] held_slots[$];
  logic [alle_pkg::SLOT_IDX_BITS-1:0] spare_slots[$];

  array_linked_list_engine_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .payload         (payload),
    .slot_index      (slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot_used       (slot_used),
    .removed_payload (removed_payload),
    .is_full         (is_full),
    .is_empty        (is_empty)
  );

  alle_list_checker list_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .payload         (payload),
    .slot_index      (slot_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .slot_used       (slot_used),
    .removed_payload (removed_payload),
    .is_full         (is_full),
    .is_empty        (is_empty),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver back-pressure, changed on the falling edge like every other input
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // hang detector: any accepted word on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // offer one word, with random idle cycles before it, and hold it until taken
  task automatic send_word(input logic act,
                           input logic [alle_pkg::PORT_PAY_BITS-1:0] pay,
                           input logic [alle_pkg::SLOT_IDX_BITS-1:0] idx);
    @(negedge clk);
    quiet = (words_sent >= QUIET_FROM) && (words_sent < QUIET_TO);
    while (!quiet && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    payload    <= pay;
    slot_index <= idx;
    // pre-edge values are seen here, so this is the edge that takes the word
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic issue_insert(input logic [alle_pkg::PORT_PAY_BITS-1:0] pay,
                              input logic [alle_pkg::SLOT_IDX_BITS-1:0] idx);
    if (spare_slots.size() != 0) held_slots.push_back(spare_slots.pop_front());
    send_word(alle_pkg::ACT_INSERT, pay, idx);
  endtask

  task automatic issue_remove(input logic [alle_pkg::SLOT_IDX_BITS-1:0] idx);
    int pos;
    pos = -1;
    foreach (held_slots[i]) if (held_slots[i] == idx && pos < 0) pos = i;
    if (pos >= 0) begin
      held_slots.delete(pos);
      spare_slots.push_front(idx);
    end
    // payload is ignored on a remove, so it carries noise
    send_word(alle_pkg::ACT_REMOVE, $urandom(), idx);
  endtask

  // remove of an entry picked anywhere in the list: head, tail or middle
  task automatic remove_any_held();
    issue_remove(held_slots[$urandom_range(0, held_slots.size() - 1)]);
  endtask

  // sender holds off until every expected word has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int run_len;
    int pick;

    for (int i = 0; i < 256; i++) spare_slots.push_back(alle_pkg::SLOT_IDX_BITS'(i));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed: removes on an empty list, payload extremes, a free slot,
    // then middle, head, tail and last-entry removes
    issue_remove(8'h00);
    issue_remove(8'hFF);
    issue_insert(32'h0000_0000, 8'h00);
    issue_insert(32'hFFFF_FFFF, 8'hFF);
    issue_insert(32'hA5A5_A5A5, 8'h5A);
    issue_insert(32'h5A5A_5A5A, 8'hA5);
    issue_remove(8'hFF);
    issue_remove(8'h80);
    issue_remove(held_slots[1]);
    issue_remove(held_slots[0]);
    issue_remove(held_slots[held_slots.size() - 1]);
    issue_remove(held_slots[0]);
    issue_remove(8'h02);
    // freed slots come back in stack order
    issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
    issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
    issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
    issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
    issue_remove(held_slots[2]);
    issue_remove(held_slots[held_slots.size() - 1]);
    issue_remove(held_slots[0]);
    issue_remove(held_slots[0]);
    issue_remove(8'h7F);

    wait_results_drained();

    // random: mixed traffic, fill to full, mixed near full, drain to empty
    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      case (phase % 4)
        1: begin
          while (spare_slots.size() != 0 && words_sent < TOTAL_WORDS)
            issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
          // inserts refused while full
          repeat ($urandom_range(2, 5))
            issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
          if (phase == 1) wait_results_drained();
        end
        3: begin
          while (held_slots.size() != 0 && words_sent < TOTAL_WORDS) remove_any_held();
          // removes refused while empty
          repeat ($urandom_range(2, 4)) issue_remove(alle_pkg::SLOT_IDX_BITS'($urandom()));
        end
        default: begin
          run_len = $urandom_range(60, 140);
          repeat (run_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) issue_insert($urandom(), alle_pkg::SLOT_IDX_BITS'($urandom()));
            else if (pick < 88 && held_slots.size() != 0) remove_any_held();
            else issue_remove(alle_pkg::SLOT_IDX_BITS'($urandom()));
          end
        end
      endcase
      phase++;
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/core/alle_pkg.sv
rtl/core/alle_ctrl.sv
rtl/core/alle_datapath.sv
rtl/core/array_linked_list_engine_top.sv
sim/alle_list_checker.sv
sim/tb_array_linked_list_engine_top.sv
